[rtl/qvr_pkg.sv]
// Shared types, widths and constants of the quaternion vector rotation block.
package qvr_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned NumStages = 10;

  localparam int unsigned Sum1W     = DataW + 1;
  localparam int unsigned Prod1W    = 2 * Sum1W;
  localparam int unsigned Acc1W     = Prod1W + 4;
  localparam int unsigned PartW     = Prod1W;
  localparam int unsigned PSumW     = PartW + 1;
  localparam int unsigned QSumW     = Sum1W + 1;
  localparam int unsigned SplitW    = 33;
  localparam int unsigned HiW       = PSumW - SplitW;
  localparam int unsigned Prod2W    = HiW + QSumW;
  localparam int unsigned Acc2W     = 104;
  localparam int unsigned FracShift = 60;
  localparam int unsigned RndW      = Acc2W - FracShift;

  typedef logic signed [DataW-1:0]  word_t;
  typedef logic signed [Sum1W-1:0]  sum1_t;
  typedef logic signed [Prod1W-1:0] prod1_t;
  typedef logic signed [Acc1W-1:0]  acc1_t;
  typedef logic signed [PartW-1:0]  part_t;
  typedef logic signed [PSumW-1:0]  psum_t;
  typedef logic signed [QSumW-1:0]  qsum_t;
  typedef logic signed [Prod2W-1:0] prod2_t;
  typedef logic signed [Acc2W-1:0]  acc2_t;
  typedef logic signed [RndW-1:0]   rnd_t;

  localparam word_t WordMax    = {1'b0, {(DataW-1){1'b1}}};
  localparam word_t WordMin    = {1'b1, {(DataW-1){1'b0}}};
  localparam word_t QuatWReset = word_t'(32'h4000_0000);
  localparam acc2_t RoundBias  = acc2_t'(1) <<< (FracShift - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_QUAT_W = 3'd0,
    CFG_QUAT_X = 3'd1,
    CFG_QUAT_Y = 3'd2,
    CFG_QUAT_Z = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
  } vec_t;

  typedef struct packed {
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
    logic  overflow;
  } rot_t;

endpackage

[rtl/qvr_round_sat.sv]
// Round to nearest Q16.16 and saturate one rotated component.
module qvr_round_sat (
  input  qvr_pkg::acc2_t acc_i,
  output qvr_pkg::word_t rot_o,
  output logic           ovf_o
);

  qvr_pkg::acc2_t biased;
  qvr_pkg::rnd_t  rnd;
  logic [qvr_pkg::RndW-qvr_pkg::DataW:0] upper;

  assign biased = acc_i + qvr_pkg::RoundBias;
  assign rnd    = biased[qvr_pkg::Acc2W-1:qvr_pkg::FracShift];
  assign upper  = rnd[qvr_pkg::RndW-1:qvr_pkg::DataW-1];
  assign ovf_o  = !((&upper) || !(|upper));

  always_comb begin
    if (!ovf_o) begin
      rot_o = rnd[qvr_pkg::DataW-1:0];
    end else if (rnd[qvr_pkg::RndW-1]) begin
      rot_o = qvr_pkg::WordMin;
    end else begin
      rot_o = qvr_pkg::WordMax;
    end
  end

endmodule

[rtl/quaternion_vector_rotate.sv]
// Top level: pipelined rotation of Q16.16 vectors by a configured Q2.30 quaternion.
//
// Takes one vector per cycle and returns one rotated vector per cycle while
// the output is not stalled; each result passes through ten register stages:
// operand sums, first eight-product multiply, two combine stages, second
// operand sums, split multiply of the wide second product, partial-product
// merge, two combine stages, and round/saturate. Results come out in order;
// a stalled output holds its stage and the stages behind it fill up, so
// bubbles are squeezed out before the input is refused. Write the quaternion
// only while the pipeline is empty; the reset value is the identity rotation.
module quaternion_vector_rotate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qvr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  qvr_pkg::word_t                   cfg_wdata_i,
  input  logic                             vec_valid_i,
  output logic                             vec_ready_o,
  input  qvr_pkg::vec_t                    vec_i,
  output logic                             rot_valid_o,
  input  logic                             rot_ready_i,
  output qvr_pkg::rot_t                    rot_o
);

  qvr_pkg::word_t quat_q [4];
  qvr_pkg::word_t quat_d [4];

  logic [qvr_pkg::NumStages-1:0] vld_q, vld_d, en;

  qvr_pkg::sum1_t  s0_f_d [8], s0_f_q [8];
  qvr_pkg::sum1_t  s0_g_d [8], s0_g_q [8];
  qvr_pkg::sum1_t  qe [4], ve [4], qc [4];

  qvr_pkg::prod1_t s1_m_d [8], s1_m_q [8];

  qvr_pkg::acc1_t  s2_s_d, s2_s_q, s2_d0_d, s2_d0_q, s2_d2_d, s2_d2_q;
  qvr_pkg::acc1_t  s2_d3_d, s2_d3_q, s2_m1_d, s2_m1_q, s2_m4_d, s2_m4_q;

  qvr_pkg::acc1_t  s3_t, s3_half;
  qvr_pkg::part_t  s3_p_d [4], s3_p_q [4];

  qvr_pkg::psum_t  pe [4];
  qvr_pkg::qsum_t  ge [4];
  qvr_pkg::psum_t  s4_f_d [7], s4_f_q [7];
  qvr_pkg::qsum_t  s4_g_d [7], s4_g_q [7];

  qvr_pkg::prod2_t s5_lo_d [7], s5_lo_q [7], s5_hi_d [7], s5_hi_q [7];

  qvr_pkg::acc2_t  s6_m_d [7], s6_m_q [7];

  qvr_pkg::acc2_t  s7_s_d, s7_s_q, s7_d2_d, s7_d2_q, s7_d3_d, s7_d3_q;
  qvr_pkg::acc2_t  s7_m1_d, s7_m1_q, s7_m4_d, s7_m4_q;

  qvr_pkg::acc2_t  s8_t, s8_half;
  qvr_pkg::acc2_t  s8_r_d [3], s8_r_q [3];

  qvr_pkg::rot_t   s9_rot_d, s9_rot_q;
  logic [2:0]      ovf;

  // configuration registers
  always_comb begin
    quat_d = quat_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        qvr_pkg::CFG_QUAT_W: quat_d[0] = cfg_wdata_i;
        qvr_pkg::CFG_QUAT_X: quat_d[1] = cfg_wdata_i;
        qvr_pkg::CFG_QUAT_Y: quat_d[2] = cfg_wdata_i;
        qvr_pkg::CFG_QUAT_Z: quat_d[3] = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[0] <= qvr_pkg::QuatWReset;
      quat_q[1] <= '0;
      quat_q[2] <= '0;
      quat_q[3] <= '0;
    end else begin
      quat_q <= quat_d;
    end
  end

  // stage enables and valid bits
  always_comb begin
    en[qvr_pkg::NumStages-1] = !vld_q[qvr_pkg::NumStages-1] || rot_ready_i;
    for (int k = qvr_pkg::NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = vec_valid_i;
    end
    for (int k = 1; k < qvr_pkg::NumStages; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign vec_ready_o = en[0];
  assign rot_valid_o = vld_q[qvr_pkg::NumStages-1];
  assign rot_o       = s9_rot_q;

  // stage 0: operand sums of q * (0, v)
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qe[k] = qvr_pkg::sum1_t'(quat_q[k]);
    end
    ve[0] = '0;
    ve[1] = qvr_pkg::sum1_t'(vec_i.vec_x);
    ve[2] = qvr_pkg::sum1_t'(vec_i.vec_y);
    ve[3] = qvr_pkg::sum1_t'(vec_i.vec_z);
    s0_f_d[0] = qe[3] - qe[2];  s0_g_d[0] = ve[2] - ve[3];
    s0_f_d[1] = qe[0] + qe[1];  s0_g_d[1] = ve[0] + ve[1];
    s0_f_d[2] = qe[0] - qe[1];  s0_g_d[2] = ve[2] + ve[3];
    s0_f_d[3] = qe[2] + qe[3];  s0_g_d[3] = ve[0] - ve[1];
    s0_f_d[4] = qe[3] - qe[1];  s0_g_d[4] = ve[1] - ve[2];
    s0_f_d[5] = qe[3] + qe[1];  s0_g_d[5] = ve[1] + ve[2];
    s0_f_d[6] = qe[0] + qe[2];  s0_g_d[6] = ve[0] - ve[3];
    s0_f_d[7] = qe[0] - qe[2];  s0_g_d[7] = ve[0] + ve[3];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_f_q <= s0_f_d;
      s0_g_q <= s0_g_d;
    end
  end

  // stage 1: eight products
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      s1_m_d[k] = qvr_pkg::prod1_t'(s0_f_q[k]) * qvr_pkg::prod1_t'(s0_g_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_m_q <= s1_m_d;
    end
  end

  // stage 2: first combine
  always_comb begin
    s2_s_d  = qvr_pkg::acc1_t'(s1_m_q[5]) + qvr_pkg::acc1_t'(s1_m_q[6])
            + qvr_pkg::acc1_t'(s1_m_q[7]);
    s2_d0_d = qvr_pkg::acc1_t'(s1_m_q[0]) - qvr_pkg::acc1_t'(s1_m_q[5]);
    s2_d2_d = qvr_pkg::acc1_t'(s1_m_q[2]) - qvr_pkg::acc1_t'(s1_m_q[7]);
    s2_d3_d = qvr_pkg::acc1_t'(s1_m_q[3]) - qvr_pkg::acc1_t'(s1_m_q[6]);
    s2_m1_d = qvr_pkg::acc1_t'(s1_m_q[1]);
    s2_m4_d = qvr_pkg::acc1_t'(s1_m_q[4]);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_s_q  <= s2_s_d;
      s2_d0_q <= s2_d0_d;
      s2_d2_q <= s2_d2_d;
      s2_d3_q <= s2_d3_d;
      s2_m1_q <= s2_m1_d;
      s2_m4_q <= s2_m4_d;
    end
  end

  // stage 3: halve and finish p = q * (0, v)
  always_comb begin
    s3_t      = s2_m4_q + s2_s_q;
    s3_half   = s3_t >>> 1;
    s3_p_d[0] = qvr_pkg::part_t'(s2_d0_q + s3_half);
    s3_p_d[1] = qvr_pkg::part_t'(s2_m1_q - s2_s_q + s3_half);
    s3_p_d[2] = qvr_pkg::part_t'(s2_d2_q + s3_half);
    s3_p_d[3] = qvr_pkg::part_t'(s2_d3_q + s3_half);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_p_q <= s3_p_d;
    end
  end

  // stage 4: operand sums of p * conj(q), scalar output dropped
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pe[k] = qvr_pkg::psum_t'(s3_p_q[k]);
    end
    qc[0] = qvr_pkg::sum1_t'(quat_q[0]);
    for (int k = 1; k < 4; k++) begin
      qc[k] = -qvr_pkg::sum1_t'(quat_q[k]);
    end
    for (int k = 0; k < 4; k++) begin
      ge[k] = qvr_pkg::qsum_t'(qc[k]);
    end
    s4_f_d[0] = pe[0] + pe[1];  s4_g_d[0] = ge[0] + ge[1];
    s4_f_d[1] = pe[0] - pe[1];  s4_g_d[1] = ge[2] + ge[3];
    s4_f_d[2] = pe[2] + pe[3];  s4_g_d[2] = ge[0] - ge[1];
    s4_f_d[3] = pe[3] - pe[1];  s4_g_d[3] = ge[1] - ge[2];
    s4_f_d[4] = pe[3] + pe[1];  s4_g_d[4] = ge[1] + ge[2];
    s4_f_d[5] = pe[0] + pe[2];  s4_g_d[5] = ge[0] - ge[3];
    s4_f_d[6] = pe[0] - pe[2];  s4_g_d[6] = ge[0] + ge[3];
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_f_q <= s4_f_d;
      s4_g_q <= s4_g_d;
    end
  end

  // stage 5: split each wide operand into low and high partial products
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      s5_lo_d[k] = qvr_pkg::prod2_t'($signed({1'b0, s4_f_q[k][qvr_pkg::SplitW-1:0]}))
                 * qvr_pkg::prod2_t'(s4_g_q[k]);
      s5_hi_d[k] = qvr_pkg::prod2_t'($signed(s4_f_q[k][qvr_pkg::PSumW-1:qvr_pkg::SplitW]))
                 * qvr_pkg::prod2_t'(s4_g_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_lo_q <= s5_lo_d;
      s5_hi_q <= s5_hi_d;
    end
  end

  // stage 6: merge partial products
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      s6_m_d[k] = (qvr_pkg::acc2_t'(s5_hi_q[k]) <<< qvr_pkg::SplitW)
                + qvr_pkg::acc2_t'(s5_lo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_m_q <= s6_m_d;
    end
  end

  // stage 7: second combine
  always_comb begin
    s7_s_d  = s6_m_q[4] + s6_m_q[5] + s6_m_q[6];
    s7_d2_d = s6_m_q[1] - s6_m_q[6];
    s7_d3_d = s6_m_q[2] - s6_m_q[5];
    s7_m1_d = s6_m_q[0];
    s7_m4_d = s6_m_q[3];
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_s_q  <= s7_s_d;
      s7_d2_q <= s7_d2_d;
      s7_d3_q <= s7_d3_d;
      s7_m1_q <= s7_m1_d;
      s7_m4_q <= s7_m4_d;
    end
  end

  // stage 8: halve and finish the vector part
  always_comb begin
    s8_t      = s7_m4_q + s7_s_q;
    s8_half   = s8_t >>> 1;
    s8_r_d[0] = s7_m1_q - s7_s_q + s8_half;
    s8_r_d[1] = s7_d2_q + s8_half;
    s8_r_d[2] = s7_d3_q + s8_half;
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_r_q <= s8_r_d;
    end
  end

  // stage 9: round, saturate, hold for output
  qvr_round_sat u_round_x (
    .acc_i (s8_r_q[0]),
    .rot_o (s9_rot_d.rot_x),
    .ovf_o (ovf[0])
  );

  qvr_round_sat u_round_y (
    .acc_i (s8_r_q[1]),
    .rot_o (s9_rot_d.rot_y),
    .ovf_o (ovf[1])
  );

  qvr_round_sat u_round_z (
    .acc_i (s8_r_q[2]),
    .rot_o (s9_rot_d.rot_z),
    .ovf_o (ovf[2])
  );

  assign s9_rot_d.overflow = |ovf;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      s9_rot_q <= s9_rot_d;
    end
  end

  logic in_acc, out_acc;
  assign in_acc  = vec_valid_i && vec_ready_o;
  assign out_acc = rot_valid_o && rot_ready_i;

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vec_ready_o |-> ((&vld_q) && !rot_ready_i))
    else $error("input refused while the pipeline has room");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(vld_q) == $past($countones(vld_q))
      + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or duplicated in the pipeline");

  a_overflow_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rot_valid_o && rot_o.overflow) |->
      (rot_o.rot_x == qvr_pkg::WordMax || rot_o.rot_x == qvr_pkg::WordMin ||
       rot_o.rot_y == qvr_pkg::WordMax || rot_o.rot_y == qvr_pkg::WordMin ||
       rot_o.rot_z == qvr_pkg::WordMax || rot_o.rot_z == qvr_pkg::WordMin))
    else $error("overflow flagged without a saturated component");

endmodule
